// ===== rtl/core/mtfr_pkg.sv =====
`timescale 1ns / 1ps

package mtfr_pkg;

	// Sizing of the slot row and the item table.
	localparam int MAX_ITEMS  = 1024;
	localparam int SLOTS      = 2048;

	localparam int SLOT_W     = $clog2(SLOTS);
	localparam int NODE_W     = SLOT_W + 1;
	localparam int TREE_DEPTH = 2 * SLOTS;
	localparam int CNT_W      = SLOT_W + 1;
	localparam int NEXT_W     = SLOT_W + 1;
	localparam int ITEM_AW    = $clog2(MAX_ITEMS);
	localparam int EFF_MAX    = (MAX_ITEMS < SLOTS) ? MAX_ITEMS : SLOTS;

	// Fixed field widths of the ports.
	localparam int ITEM_W     = 11;
	localparam int ABOVE_W    = 10;
	localparam int STATUS_W   = 2;
	localparam int ABOVE_MAX  = (2 ** ABOVE_W) - 1;

	// Walk sequencing.
	localparam int STEP_W     = $clog2(NODE_W);
	localparam int QUERY_LAST = SLOT_W - 1;
	localparam int RMW_LAST   = SLOT_W;
	localparam int SWEEP_LAST = TREE_DEPTH - 1;

	// Operation codes on the op field.
	localparam logic OP_RESTART = 1'b0;
	localparam logic OP_ACCESS  = 1'b1;

	// Result status codes.
	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

	// Walk register operations.
	localparam logic [2:0] WALK_HOLD  = 3'd0;
	localparam logic [2:0] WALK_STEP  = 3'd1;
	localparam logic [2:0] WALK_RDATA = 3'd2;
	localparam logic [2:0] WALK_OLD   = 3'd3;
	localparam logic [2:0] WALK_NEW   = 3'd4;

	typedef struct packed {
		logic              capture;
		logic              sweep_wr;
		logic              build_done;
		logic [NODE_W-1:0] sweep_node;
		logic [2:0]        walk_op;
		logic              query_rd;
		logic              rmw_rd;
		logic              rmw_first;
		logic              rmw_val;
		logic              commit;
		logic              out_load;
	} mtfr_cmd_t;

	typedef struct packed {
		logic restart;
		logic bad;
		logic out_free;
	} mtfr_sts_t;

endpackage

// ===== rtl/core/mtfr_ram.sv =====
`timescale 1ns / 1ps

module mtfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/mtfr_ctrl.sv =====
`timescale 1ns / 1ps

module mtfr_ctrl
	import mtfr_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  mtfr_sts_t sts,
	output mtfr_cmd_t cmd
);

	localparam logic [2:0] S_BUILD  = 3'd0;
	localparam logic [2:0] S_IDLE   = 3'd1;
	localparam logic [2:0] S_DECIDE = 3'd2;
	localparam logic [2:0] S_LOAD   = 3'd3;
	localparam logic [2:0] S_QUERY  = 3'd4;
	localparam logic [2:0] S_CLR    = 3'd5;
	localparam logic [2:0] S_SET    = 3'd6;
	localparam logic [2:0] S_OUT    = 3'd7;

	logic [2:0]        state_q, state_d;
	logic [STEP_W-1:0] step_q, step_d;
	logic [NODE_W-1:0] sweep_q, sweep_d;
	logic              reply_q, reply_d;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		step_d   = step_q;
		sweep_d  = sweep_q;
		reply_d  = reply_q;
		in_stall = (state_q != S_IDLE);
		unique case (state_q)
			S_BUILD: begin
				cmd.sweep_wr   = 1'b1;
				cmd.sweep_node = sweep_q;
				if (sweep_q == NODE_W'(SWEEP_LAST)) begin
					cmd.build_done = 1'b1;
					reply_d        = 1'b0;
					state_d        = reply_q ? S_OUT : S_IDLE;
				end else begin
					sweep_d = sweep_q + NODE_W'(1);
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_DECIDE;
				end
			end
			S_DECIDE: begin
				// The item table read for the access is issued here.
				if (sts.restart) begin
					sweep_d = NODE_W'(1);
					reply_d = 1'b1;
					state_d = S_BUILD;
				end else if (sts.bad) begin
					state_d = S_OUT;
				end else begin
					state_d = S_LOAD;
				end
			end
			S_LOAD: begin
				cmd.walk_op = WALK_RDATA;
				step_d      = '0;
				state_d     = S_QUERY;
			end
			S_QUERY: begin
				cmd.query_rd = 1'b1;
				if (step_q == STEP_W'(QUERY_LAST)) begin
					cmd.walk_op = WALK_OLD;
					step_d      = '0;
					state_d     = S_CLR;
				end else begin
					cmd.walk_op = WALK_STEP;
					step_d      = step_q + STEP_W'(1);
				end
			end
			S_CLR: begin
				cmd.rmw_rd    = 1'b1;
				cmd.rmw_first = (step_q == '0);
				cmd.rmw_val   = 1'b0;
				if (step_q == STEP_W'(RMW_LAST)) begin
					cmd.walk_op = WALK_NEW;
					step_d      = '0;
					state_d     = S_SET;
				end else begin
					cmd.walk_op = WALK_STEP;
					step_d      = step_q + STEP_W'(1);
				end
			end
			S_SET: begin
				cmd.rmw_rd    = 1'b1;
				cmd.rmw_first = (step_q == '0);
				cmd.rmw_val   = 1'b1;
				if (step_q == STEP_W'(RMW_LAST)) begin
					cmd.commit = 1'b1;
					step_d     = '0;
					state_d    = S_OUT;
				end else begin
					cmd.walk_op = WALK_STEP;
					step_d      = step_q + STEP_W'(1);
				end
			end
			S_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_BUILD;
			step_q  <= '0;
			sweep_q <= NODE_W'(1);
			reply_q <= 1'b0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
			sweep_q <= sweep_d;
			reply_q <= reply_d;
		end
	end

	a_sweep_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_BUILD |-> sweep_q != '0)
		else $error("sweep addressed the unused tree node");

	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLR || state_q == S_SET) |-> step_q <= STEP_W'(RMW_LAST))
		else $error("tree update walk ran past the root");

endmodule

// ===== rtl/core/mtfr_datapath.sv =====
`timescale 1ns / 1ps

module mtfr_datapath
	import mtfr_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  mtfr_cmd_t           cmd,
	output mtfr_sts_t           sts,
	input  logic                cfg_wr,
	input  logic [ITEM_W-1:0]   cfg_data,
	input  logic                in_op,
	input  logic [ITEM_W-1:0]   in_item,
	input  logic                out_stall,
	output logic                out_valid,
	output logic [ABOVE_W-1:0]  out_above,
	output logic [STATUS_W-1:0] out_status
);

	// Count held by a tree node right after a restart with cnt items:
	// the number of slots below cnt inside the node's span.
	function automatic logic [CNT_W-1:0] node_init(input logic [NODE_W-1:0] node,
		input logic [ITEM_W-1:0] cnt);
		logic [STEP_W-1:0] lvl;
		logic [STEP_W-1:0] sh;
		logic [NODE_W:0]   base;
		logic [NODE_W:0]   span;
		logic [NODE_W:0]   cnt_x;
		lvl = '0;
		for (int i = 0; i < NODE_W; i++) begin
			if (node[i]) begin
				lvl = STEP_W'(i);
			end
		end
		sh    = STEP_W'(SLOT_W) - lvl;
		base  = ((NODE_W + 1)'(node) - ((NODE_W + 1)'(1) << lvl)) << sh;
		span  = (NODE_W + 1)'(1) << sh;
		cnt_x = (NODE_W + 1)'(cnt);
		if (cnt_x <= base) begin
			node_init = '0;
		end else if ((cnt_x - base) >= span) begin
			node_init = CNT_W'(span);
		end else begin
			node_init = CNT_W'(cnt_x - base);
		end
	endfunction

	logic [ITEM_W-1:0]   item_count_q;
	logic [ITEM_W-1:0]   eff_cnt;
	logic [ITEM_W-1:0]   eff_q;
	logic [ITEM_W-1:0]   item_q;
	logic [ITEM_W-1:0]   item_m1;
	logic                op_q;
	logic [STATUS_W-1:0] res_status_q;
	logic [CNT_W-1:0]    acc_q;
	logic [NEXT_W-1:0]   next_slot_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [NODE_W-1:0]   walk_q;

	logic                acc_s1;
	logic                wr_s1;
	logic                first_s1;
	logic                val_s1;
	logic [NODE_W-1:0]   addr_s1;
	logic [CNT_W-1:0]    delta_q;
	logic [CNT_W-1:0]    delta_eff;

	logic                out_valid_q;
	logic [ABOVE_W-1:0]  above_q;
	logic [STATUS_W-1:0] status_q;

	logic                tree_we;
	logic [NODE_W-1:0]   tree_waddr;
	logic [CNT_W-1:0]    tree_wdata;
	logic [NODE_W-1:0]   tree_raddr;
	logic [CNT_W-1:0]    tree_rdata;

	logic                slot_we;
	logic [ITEM_AW-1:0]  slot_waddr;
	logic [SLOT_W-1:0]   slot_wdata;
	logic [SLOT_W-1:0]   slot_rdata;
	logic [NODE_W-1:0]   sweep_idx;
	logic [NODE_W-1:0]   sweep_slot;

	assign eff_cnt = (int'(item_count_q) > EFF_MAX) ? ITEM_W'(EFF_MAX) : item_count_q;
	assign item_m1 = item_q - ITEM_W'(1);

	assign sts.restart  = (op_q == OP_RESTART);
	assign sts.bad      = (res_status_q != STATUS_OK);
	assign sts.out_free = !out_valid_q || !out_stall;

	// Configuration and item capture.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_count_q <= ITEM_W'(1);
			eff_q        <= '0;
			op_q         <= OP_ACCESS;
			res_status_q <= STATUS_OK;
		end else begin
			if (cfg_wr) begin
				item_count_q <= cfg_data;
			end
			if (cmd.capture) begin
				op_q  <= in_op;
				eff_q <= eff_cnt;
				if (in_op == OP_RESTART) begin
					res_status_q <= STATUS_OK;
				end else if (in_item == '0 || in_item > eff_cnt) begin
					res_status_q <= STATUS_RANGE;
				end else if (next_slot_q >= NEXT_W'(SLOTS)) begin
					res_status_q <= STATUS_FULL;
				end else begin
					res_status_q <= STATUS_OK;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= in_item;
		end
	end

	// Walk register: a tree node index moving from leaf toward root.
	always_ff @(posedge clk) begin
		unique case (cmd.walk_op)
			WALK_STEP:  walk_q <= walk_q >> 1;
			WALK_RDATA: begin
				slot_q <= slot_rdata;
				walk_q <= NODE_W'(SLOTS) | NODE_W'(slot_rdata);
			end
			WALK_OLD:   walk_q <= NODE_W'(SLOTS) | NODE_W'(slot_q);
			WALK_NEW:   walk_q <= NODE_W'(SLOTS) | NODE_W'(next_slot_q[SLOT_W-1:0]);
			default:    walk_q <= walk_q;
		endcase
	end

	// Read stage of the tree walks.
	assign tree_raddr = cmd.query_rd ? (walk_q ^ NODE_W'(1)) : walk_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_s1   <= 1'b0;
			wr_s1    <= 1'b0;
			first_s1 <= 1'b0;
		end else begin
			acc_s1   <= cmd.query_rd && !walk_q[0];
			wr_s1    <= cmd.rmw_rd;
			first_s1 <= cmd.rmw_first;
		end
	end

	always_ff @(posedge clk) begin
		val_s1  <= cmd.rmw_val;
		addr_s1 <= walk_q;
		if (wr_s1) begin
			delta_q <= delta_eff;
		end
	end

	// The leaf sets the change; every ancestor takes the same change.
	assign delta_eff = first_s1 ? (CNT_W'(val_s1) - tree_rdata) : delta_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (cmd.capture) begin
			acc_q <= '0;
		end else if (acc_s1) begin
			acc_q <= acc_q + tree_rdata;
		end
	end

	// Tree write port: build sweep or read-modify-write.
	always_comb begin
		if (cmd.sweep_wr) begin
			tree_we    = 1'b1;
			tree_waddr = cmd.sweep_node;
			tree_wdata = node_init(cmd.sweep_node, eff_q);
		end else begin
			tree_we    = wr_s1;
			tree_waddr = addr_s1;
			tree_wdata = tree_rdata + delta_eff;
		end
	end

	// Item table write port: restart fill or access commit.
	assign sweep_idx  = cmd.sweep_node - NODE_W'(1);
	assign sweep_slot = NODE_W'(eff_q) - cmd.sweep_node;

	always_comb begin
		if (cmd.sweep_wr) begin
			slot_we    = (sweep_idx < NODE_W'(eff_q));
			slot_waddr = sweep_idx[ITEM_AW-1:0];
			slot_wdata = sweep_slot[SLOT_W-1:0];
		end else begin
			slot_we    = cmd.commit;
			slot_waddr = item_m1[ITEM_AW-1:0];
			slot_wdata = next_slot_q[SLOT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_slot_q <= '0;
		end else if (cmd.build_done) begin
			next_slot_q <= NEXT_W'(eff_q);
		end else if (cmd.commit) begin
			next_slot_q <= next_slot_q + NEXT_W'(1);
		end
	end

	mtfr_ram #(
		.WIDTH (CNT_W),
		.DEPTH (TREE_DEPTH)
	) u_tree_ram (
		.clk   (clk),
		.we    (tree_we),
		.waddr (tree_waddr),
		.wdata (tree_wdata),
		.raddr (tree_raddr),
		.rdata (tree_rdata)
	);

	mtfr_ram #(
		.WIDTH (SLOT_W),
		.DEPTH (MAX_ITEMS)
	) u_slot_ram (
		.clk   (clk),
		.we    (slot_we),
		.waddr (slot_waddr),
		.wdata (slot_wdata),
		.raddr (item_m1[ITEM_AW-1:0]),
		.rdata (slot_rdata)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			status_q <= res_status_q;
			above_q  <= (acc_q > CNT_W'(ABOVE_MAX)) ? ABOVE_W'(ABOVE_MAX)
				: acc_q[ABOVE_W-1:0];
		end
	end

	assign out_valid  = out_valid_q;
	assign out_above  = above_q;
	assign out_status = status_q;

	a_no_write_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.sweep_wr && wr_s1))
		else $error("build sweep and tree update wrote in the same cycle");

	a_query_below_root: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.query_rd |-> walk_q > NODE_W'(1))
		else $error("rank query reached the root");

	a_first_is_leaf: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_s1 && first_s1) |-> addr_s1 >= NODE_W'(SLOTS))
		else $error("tree update did not start at a leaf");

	a_next_slot_bound: assert property (@(posedge clk) disable iff (!arst_n)
		next_slot_q <= NEXT_W'(SLOTS))
		else $error("fresh slot pointer ran past the slot row");

endmodule

// ===== rtl/core/move_to_front_rank_engine.sv =====
`timescale 1ns / 1ps

// Move-to-front rank engine. The block keeps a stack of numbered items in a
// row of slots, with a segment tree of occupancy counts kept in one RAM. An
// input transfer with op 0 restarts the stack with item_count items, capped
// at 1024 (item 1 on top); one with op 1 accesses an item, returns how many
// items sit above it and moves it to the top. Every input transfer gives
// exactly one output transfer. An access runs a rank query from the leaf up
// to the level below the root, then a leaf clear and a leaf set from the
// leaf up to the root, all through the single read port of the tree RAM,
// with states to decide, to read the item table, to hand the result to the
// output register and to return to idle; no new input transfer is taken
// until the result is handed on. A restart rewrites every tree node but
// the unused node 0, and the item table entries of the restarted items, in
// one sweep; a rejected access (item out of range or fresh slots used up)
// leaves the stack untouched. After reset the same sweep clears the tree,
// and in_stall stays high until it ends. The next input transfer is taken
// while a finished result still waits in the output register. The item_count
// register is written through its own port, which is always ready; it should
// only be written while no item is in flight.
module move_to_front_rank_engine
	import mtfr_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,

	// Input channel.
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                op,
	input  logic [ITEM_W-1:0]   item,

	// Result channel.
	output logic                out_valid,
	input  logic                out_stall,
	output logic [ABOVE_W-1:0]  items_above,
	output logic [STATUS_W-1:0] status,

	// Configuration write channel for item_count.
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [ITEM_W-1:0]   item_count
);

	mtfr_cmd_t cmd;
	mtfr_sts_t sts;

	// The register port never pushes back.
	assign cfg_ready = 1'b1;

	// The controller sequences the build sweep, the three tree walks of an
	// access and the hand-off to the output register.
	mtfr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// The datapath holds the tree RAM, the item table, the fresh slot
	// pointer, the rank accumulator and the output register.
	mtfr_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.cfg_wr     (cfg_valid && cfg_ready),
		.cfg_data   (item_count),
		.in_op      (op),
		.in_item    (item),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.out_above  (items_above),
		.out_status (status)
	);

endmodule
